@@ src/pcae_pkg.sv @@
// ----------------------------------------------------------------------------
// pcae_pkg
// Shared types and constants of the pulse charge and amplitude extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package pcae_pkg;

  // waveform geometry
  localparam int WAVE_LEN    = 1024;
  localparam int BASE_LEN    = 20;
  localparam int SAMPLE_BITS = 16;

  // field widths fixed by the interface
  localparam int IN_SAMPLE_W = 16;
  localparam int IDX_W       = 10;
  localparam int FLOOR_W     = 16;
  localparam int CHARGE_W    = 32;
  localparam int AMP_W       = 22;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // internal widths
  localparam int BLEN_W   = $clog2(BASE_LEN + 1);
  localparam int BSUM_W   = SAMPLE_BITS + BLEN_W;
  localparam int WSUM_W   = SAMPLE_BITS + $clog2(WAVE_LEN);
  localparam int WLEN_W   = IDX_W + 1;
  localparam int CPROD_W  = WLEN_W + BSUM_W;
  localparam int WPROD_W  = WSUM_W + BLEN_W;
  localparam int MPROD_W  = SAMPLE_BITS + BLEN_W;
  localparam int CDIFF_W  = CHARGE_W + 1;
  localparam int ADIFF_W  = AMP_W + 1;

  // queue between front and back
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHARGE_START   = 3'd0,
    CFG_CHARGE_END     = 3'd1,
    CFG_MIN_END        = 3'd2,
    CFG_BASELINE_FLOOR = 3'd3,
    CFG_CHARGE_LOW     = 3'd4,
    CFG_CHARGE_HIGH    = 3'd5,
    CFG_AMP_LOW        = 3'd6,
    CFG_AMP_HIGH       = 3'd7
  } cfg_idx_e;

  // configuration register reset values
  localparam logic [IDX_W-1:0]    RST_CHARGE_START   = IDX_W'(300);
  localparam logic [IDX_W-1:0]    RST_CHARGE_END     = IDX_W'(949);
  localparam logic [IDX_W-1:0]    RST_MIN_END        = IDX_W'(949);
  localparam logic [FLOOR_W-1:0]  RST_BASELINE_FLOOR = FLOOR_W'(14600);
  localparam logic [CHARGE_W-1:0] RST_CHARGE_LOW     = CHARGE_W'(2960000);
  localparam logic [CHARGE_W-1:0] RST_CHARGE_HIGH    = CHARGE_W'(4160000);
  localparam logic [AMP_W-1:0]    RST_AMP_LOW        = AMP_W'(38000);
  localparam logic [AMP_W-1:0]    RST_AMP_HIGH       = AMP_W'(57000);

  typedef struct packed {
    logic [IDX_W-1:0]    charge_start;
    logic [IDX_W-1:0]    charge_end;
    logic [IDX_W-1:0]    min_end;
    logic [FLOOR_W-1:0]  baseline_floor;
    logic [CHARGE_W-1:0] charge_low;
    logic [CHARGE_W-1:0] charge_high;
    logic [AMP_W-1:0]    amp_low;
    logic [AMP_W-1:0]    amp_high;
  } cfg_t;

  // request payloads
  typedef struct packed {
    logic [IN_SAMPLE_W-1:0] sample;
    logic                   last_sample;
  } pca_in_t;

  typedef struct packed {
    logic [CHARGE_W-1:0] charge_scaled;
    logic [AMP_W-1:0]    amplitude_scaled;
    logic                baseline_bad;
    logic                charge_pass;
    logic                amp_pass;
  } pca_out_t;

  // classified sample travelling from front to back
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   base;
    logic                   win;
    logic                   mn;
    logic                   low;
    logic                   last;
  } item_t;

endpackage

`default_nettype wire

@@ src/pcae_front.sv @@
// ----------------------------------------------------------------------------
// pcae_front
// Accepts samples, tracks the sample index and tags each sample with the
// windows it falls in.
// ----------------------------------------------------------------------------
`default_nettype none

module pcae_front import pcae_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire pca_in_t in_data_i,
  input  wire cfg_t    cfg_i,
  output logic         q_valid_o,
  input  wire logic    q_ready_i,
  output item_t        q_item_o
);

  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   past_end_q, past_end_d;
  logic                   accept;
  logic                   active;
  logic                   after_start;
  logic [SAMPLE_BITS-1:0] smp;

  assign in_ready_o = q_ready_i;
  assign q_valid_o  = in_valid_i;
  assign accept     = in_valid_i & q_ready_i;

  // classification of the current sample
  always_comb begin
    active      = ~past_end_q;
    smp         = in_data_i.sample[SAMPLE_BITS-1:0];
    after_start = idx_q >= cfg_i.charge_start;
    q_item_o.sample = smp;
    q_item_o.base   = active & (idx_q < IDX_W'(BASE_LEN));
    q_item_o.win    = active & after_start & (idx_q <= cfg_i.charge_end);
    q_item_o.mn     = active & after_start & (idx_q <= cfg_i.min_end);
    q_item_o.low    = q_item_o.base & (FLOOR_W'(smp) < cfg_i.baseline_floor);
    q_item_o.last   = in_data_i.last_sample;
  end

  // sample index and overrun flag
  always_comb begin
    idx_d      = idx_q;
    past_end_d = past_end_q;
    if (accept) begin
      if (in_data_i.last_sample) begin
        idx_d      = '0;
        past_end_d = 1'b0;
      end else if (active) begin
        if (idx_q == IDX_W'(WAVE_LEN - 1)) begin
          past_end_d = 1'b1;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      past_end_q <= 1'b0;
    end else begin
      idx_q      <= idx_d;
      past_end_q <= past_end_d;
    end
  end

endmodule

`default_nettype wire

@@ src/pcae_queue.sv @@
// ----------------------------------------------------------------------------
// pcae_queue
// Short first-in first-out queue of classified samples between front and
// back.
// ----------------------------------------------------------------------------
`default_nettype none

module pcae_queue import pcae_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire item_t push_item_i,
  output logic       pop_valid_o,
  input  wire logic  pop_ready_i,
  output item_t      pop_item_o
);

  item_t              mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_PTR_W:0]   cnt_q, cnt_d;
  logic               push, pop;

  assign push_ready_o = cnt_q != (Q_PTR_W + 1)'(Q_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // fill count
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + (Q_PTR_W + 1)'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - (Q_PTR_W + 1)'(1);
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

@@ src/pcae_back.sv @@
// ----------------------------------------------------------------------------
// pcae_back
// Accumulates baseline, window sum and minimum, then turns the totals of a
// finished waveform into scaled charge, amplitude and cut flags.
// ----------------------------------------------------------------------------
`default_nettype none

module pcae_back import pcae_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  pop_valid_i,
  output logic       pop_ready_o,
  input  wire item_t pop_item_i,
  input  wire cfg_t  cfg_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output pca_out_t   out_data_o
);

  logic                   en, pop;

  // accumulators
  logic [BSUM_W-1:0]      bsum_q, bsum_nx;
  logic [WSUM_W-1:0]      wsum_q, wsum_nx;
  logic [SAMPLE_BITS-1:0] min_q, min_nx;
  logic                   bad_q, bad_nx;

  // stage 1: waveform totals
  logic                   s1_v_q;
  logic [BSUM_W-1:0]      s1_bsum_q;
  logic [WSUM_W-1:0]      s1_wsum_q;
  logic [SAMPLE_BITS-1:0] s1_min_q;
  logic                   s1_bad_q;

  // stage 2: products
  logic                   s2_v_q;
  logic [WLEN_W-1:0]      wlen;
  logic [CPROD_W-1:0]     s2_pc_q;
  logic [WPROD_W-1:0]     s2_pw_q;
  logic [BSUM_W-1:0]      s2_bsum_q;
  logic [MPROD_W-1:0]     s2_pm_q;
  logic                   s2_bad_q;

  // stage 3: saturated results
  logic                   s3_v_q;
  logic [CDIFF_W-1:0]     cdiff;
  logic [ADIFF_W-1:0]     adiff;
  logic [CHARGE_W-1:0]    charge_sat;
  logic [AMP_W-1:0]       amp_sat;
  logic [CHARGE_W-1:0]    s3_charge_q;
  logic [AMP_W-1:0]       s3_amp_q;
  logic                   s3_bad_q;

  // output register
  logic                   out_valid_q;
  pca_out_t               out_q;

  assign en          = ~out_valid_q | out_ready_i;
  assign pop_ready_o = en;
  assign pop         = pop_valid_i & en;

  // per-sample update
  always_comb begin
    bsum_nx = bsum_q;
    wsum_nx = wsum_q;
    min_nx  = min_q;
    bad_nx  = bad_q | pop_item_i.low;
    if (pop_item_i.base) begin
      bsum_nx = bsum_q + BSUM_W'(pop_item_i.sample);
    end
    if (pop_item_i.win) begin
      wsum_nx = wsum_q + WSUM_W'(pop_item_i.sample);
    end
    if (pop_item_i.mn && (pop_item_i.sample < min_q)) begin
      min_nx = pop_item_i.sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsum_q <= '0;
      wsum_q <= '0;
      min_q  <= '1;
      bad_q  <= 1'b0;
    end else if (pop) begin
      if (pop_item_i.last) begin
        bsum_q <= '0;
        wsum_q <= '0;
        min_q  <= '1;
        bad_q  <= 1'b0;
      end else begin
        bsum_q <= bsum_nx;
        wsum_q <= wsum_nx;
        min_q  <= min_nx;
        bad_q  <= bad_nx;
      end
    end
  end

  // window length from the registers
  always_comb begin
    wlen = '0;
    if (cfg_i.charge_end >= cfg_i.charge_start) begin
      wlen = WLEN_W'(cfg_i.charge_end) - WLEN_W'(cfg_i.charge_start) + WLEN_W'(1);
    end
  end

  // differences and saturation
  always_comb begin
    cdiff = CDIFF_W'(s2_pc_q) - CDIFF_W'(s2_pw_q);
    adiff = ADIFF_W'(s2_bsum_q) - ADIFF_W'(s2_pm_q);
    if (cdiff[CDIFF_W-1] != cdiff[CDIFF_W-2]) begin
      charge_sat = cdiff[CDIFF_W-1] ? {1'b1, {(CHARGE_W-1){1'b0}}}
                                    : {1'b0, {(CHARGE_W-1){1'b1}}};
    end else begin
      charge_sat = cdiff[CHARGE_W-1:0];
    end
    if (adiff[ADIFF_W-1] != adiff[ADIFF_W-2]) begin
      amp_sat = adiff[ADIFF_W-1] ? {1'b1, {(AMP_W-1){1'b0}}}
                                 : {1'b0, {(AMP_W-1){1'b1}}};
    end else begin
      amp_sat = adiff[AMP_W-1:0];
    end
  end

  // result pipeline valid bits, all stages move together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_v_q      <= pop & pop_item_i.last;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      out_valid_q <= s3_v_q;
    end
  end

  // result pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_bsum_q <= bsum_nx;
      s1_wsum_q <= wsum_nx;
      s1_min_q  <= min_nx;
      s1_bad_q  <= bad_nx;

      s2_pc_q   <= CPROD_W'(wlen) * CPROD_W'(s1_bsum_q);
      s2_pw_q   <= WPROD_W'(s1_wsum_q) * WPROD_W'(BASE_LEN);
      s2_pm_q   <= MPROD_W'(s1_min_q) * MPROD_W'(BASE_LEN);
      s2_bsum_q <= s1_bsum_q;
      s2_bad_q  <= s1_bad_q;

      s3_charge_q <= charge_sat;
      s3_amp_q    <= amp_sat;
      s3_bad_q    <= s2_bad_q;

      out_q.charge_scaled    <= s3_charge_q;
      out_q.amplitude_scaled <= s3_amp_q;
      out_q.baseline_bad     <= s3_bad_q;
      out_q.charge_pass      <= ~s3_bad_q
                                & ($signed(s3_charge_q) > $signed(cfg_i.charge_low))
                                & ($signed(s3_charge_q) < $signed(cfg_i.charge_high));
      out_q.amp_pass         <= ~s3_bad_q
                                & ($signed(s3_amp_q) > $signed(cfg_i.amp_low))
                                & ($signed(s3_amp_q) < $signed(cfg_i.amp_high));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ src/pulse_charge_amplitude_extract.sv @@
// ----------------------------------------------------------------------------
// pulse_charge_amplitude_extract
// Baseline-subtracted pulse charge and amplitude of digitizer waveforms.
//
//   channel  direction  handshake           payload
//   in       request    in_valid/in_ready   pca_in_t  (sample, last_sample)
//   out      result     out_valid/out_ready pca_out_t (charge, amplitude, flags)
//   cfg      write      cfg_we              cfg_idx_i, cfg_wdata_i
//
// One sample is taken every cycle while the queue has room; the per-sample
// add, compare and minimum update in the back sets that figure.
// A result passes the totals, products and saturation stages, then the output
// register. The four-entry queue lets the front keep taking samples while the
// output register is stalled; a full queue drops in_ready.
// Reset clears the index, the accumulators and the result pipeline and loads
// the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_charge_amplitude_extract import pcae_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire pca_in_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output pca_out_t                   out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t  cfg_q;
  logic  q_push_valid, q_push_ready;
  item_t q_push_item;
  logic  q_pop_valid, q_pop_ready;
  item_t q_pop_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.charge_start   <= RST_CHARGE_START;
      cfg_q.charge_end     <= RST_CHARGE_END;
      cfg_q.min_end        <= RST_MIN_END;
      cfg_q.baseline_floor <= RST_BASELINE_FLOOR;
      cfg_q.charge_low     <= RST_CHARGE_LOW;
      cfg_q.charge_high    <= RST_CHARGE_HIGH;
      cfg_q.amp_low        <= RST_AMP_LOW;
      cfg_q.amp_high       <= RST_AMP_HIGH;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CHARGE_START:   cfg_q.charge_start   <= cfg_wdata_i[IDX_W-1:0];
        CFG_CHARGE_END:     cfg_q.charge_end     <= cfg_wdata_i[IDX_W-1:0];
        CFG_MIN_END:        cfg_q.min_end        <= cfg_wdata_i[IDX_W-1:0];
        CFG_BASELINE_FLOOR: cfg_q.baseline_floor <= cfg_wdata_i[FLOOR_W-1:0];
        CFG_CHARGE_LOW:     cfg_q.charge_low     <= cfg_wdata_i[CHARGE_W-1:0];
        CFG_CHARGE_HIGH:    cfg_q.charge_high    <= cfg_wdata_i[CHARGE_W-1:0];
        CFG_AMP_LOW:        cfg_q.amp_low        <= cfg_wdata_i[AMP_W-1:0];
        CFG_AMP_HIGH:       cfg_q.amp_high       <= cfg_wdata_i[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // sample indexing and classification
  pcae_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .q_valid_o  (q_push_valid),
    .q_ready_i  (q_push_ready),
    .q_item_o   (q_push_item)
  );

  // decoupling queue
  pcae_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_item_i  (q_push_item),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_item_o   (q_pop_item)
  );

  // accumulation and result arithmetic
  pcae_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_item_i  (q_pop_item),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ src/pcae_checker.sv @@
// ----------------------------------------------------------------------------
// pcae_checker
// Port-level checks of the pulse charge and amplitude extractor.
// ----------------------------------------------------------------------------
`default_nettype none

module pcae_checker import pcae_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire pca_in_t               in_data_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire pca_out_t              out_data_o,
  input wire logic                  cfg_we_i,
  input wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [15:0] pending_q;
  logic        last_in, res_out;

  assign last_in = in_valid_i & in_ready_o & in_data_i.last_sample;
  assign res_out = out_valid_o & out_ready_i;

  // waveforms ended but not yet reported
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 16'(last_in) - 16'(res_out);
    end
  end

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // nothing comes out straight after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

  // a bad baseline never passes a cut
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.baseline_bad |-> !out_data_o.charge_pass
                                            && !out_data_o.amp_pass)
    else $error("pass flag with bad baseline");

  // every result belongs to an ended waveform
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out |-> (pending_q != 16'd0) || last_in)
    else $error("result without a last sample");

  // no configuration write while a waveform result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> (pending_q == 16'd0) && !$isunknown({cfg_idx_i, cfg_wdata_i}))
    else $error("configuration write with a result pending");

endmodule

bind pulse_charge_amplitude_extract pcae_checker u_pcae_checker (.*);

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pulse charge and amplitude extractor. Waveforms
// are streamed in as sample requests under random bursts and gaps, results are
// taken under a varying stall pattern with one long hold-off, and every
// result is checked field by field against an in-bench prediction of the
// baseline, window sum, minimum and cut logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import pcae_pkg::*;

  localparam int RUN_LIMIT   = 400000;
  localparam int SETTLE      = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int CHG_CUT_MAX = 1342156800;
  localparam int AMP_CUT_MAX = 1310700;

  typedef enum {WIN_SHORT, WIN_FULL, WIN_TOP} win_kind_e;
  typedef enum {SHAPE_NOISE, SHAPE_PULSE} shape_e;
  typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_SKIP} rx_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  pca_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  pca_out_t              out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_CHARGE_START;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  pulse_charge_amplitude_extract uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // register copy, kept in step with every write
  cfg_t cur_cfg = '{
    charge_start:   RST_CHARGE_START,
    charge_end:     RST_CHARGE_END,
    min_end:        RST_MIN_END,
    baseline_floor: RST_BASELINE_FLOOR,
    charge_low:     RST_CHARGE_LOW,
    charge_high:    RST_CHARGE_HIGH,
    amp_low:        RST_AMP_LOW,
    amp_high:       RST_AMP_HIGH
  };

  // per-waveform accumulation state
  int                     wave_idx      = 0;
  longint                 wave_base_sum = 0;
  longint                 wave_win_sum  = 0;
  logic [SAMPLE_BITS-1:0] wave_min      = '1;
  logic                   wave_bad      = 1'b0;
  logic                   wave_full     = 1'b0;

  pca_in_t  sample_fifo[$];
  pca_out_t pulse_results[$];

  int   mismatches  = 0;
  int   cycle_count = 0;
  int   burst_left  = 1;
  int   gap_left    = 0;
  int   rx_tick     = 0;
  int   hold_left   = 0;
  logic hold_go     = 1'b0;
  logic hold_done   = 1'b0;

  // fold one sample into the waveform, give the pulse result on the last one
  function automatic bit step_waveform(input pca_in_t smp, output pca_out_t res);
    logic [SAMPLE_BITS-1:0] s;
    longint wlen, charge, amp;
    logic cpass, apass;
    s = smp.sample;
    res = '0;
    if (!wave_full) begin
      if (wave_idx < BASE_LEN) begin
        wave_base_sum += s;
        if (s < cur_cfg.baseline_floor) wave_bad = 1'b1;
      end
      if (wave_idx >= cur_cfg.charge_start && wave_idx <= cur_cfg.charge_end)
        wave_win_sum += s;
      if (wave_idx >= cur_cfg.charge_start && wave_idx <= cur_cfg.min_end &&
          s < wave_min)
        wave_min = s;
      if (wave_idx + 1 >= WAVE_LEN) wave_full = 1'b1;
      else wave_idx++;
    end
    if (!smp.last_sample) return 1'b0;

    // empty window when the end lies before the start
    wlen = (cur_cfg.charge_end >= cur_cfg.charge_start) ?
           longint'(cur_cfg.charge_end) - longint'(cur_cfg.charge_start) + 1 : 0;
    charge = wlen * wave_base_sum - longint'(BASE_LEN) * wave_win_sum;
    amp = wave_base_sum - longint'(BASE_LEN) * longint'(wave_min);
    if (charge < -longint'(2147483647) - 1) charge = -longint'(2147483647) - 1;
    if (charge > longint'(2147483647)) charge = longint'(2147483647);
    if (amp < -longint'(2097152)) amp = -longint'(2097152);
    if (amp > longint'(2097151)) amp = longint'(2097151);
    cpass = !wave_bad && charge > longint'($signed(cur_cfg.charge_low)) &&
            charge < longint'($signed(cur_cfg.charge_high));
    apass = !wave_bad && amp > longint'($signed(cur_cfg.amp_low)) &&
            amp < longint'($signed(cur_cfg.amp_high));
    res.charge_scaled    = charge[CHARGE_W-1:0];
    res.amplitude_scaled = amp[AMP_W-1:0];
    res.baseline_bad     = wave_bad;
    res.charge_pass      = cpass;
    res.amp_pass         = apass;

    wave_idx      = 0;
    wave_base_sum = 0;
    wave_win_sum  = 0;
    wave_min      = '1;
    wave_bad      = 1'b0;
    wave_full     = 1'b0;
    return 1'b1;
  endfunction

  // sample driver: bursts of requests with random gaps between them
  always @(posedge clk_i) begin : sample_driver
    pca_out_t res;
    logic     offer;
    offer = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (step_waveform(in_data_i, res)) pulse_results.insert(pulse_results.size(), res);
        void'(sample_fifo.pop_front());
        offer = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (!offer) begin
        if (gap_left > 0) gap_left--;
        else if (sample_fifo.size() > 0) begin
          in_data_i <= sample_fifo[0];
          offer = 1'b1;
        end
      end
    end
    in_valid_i <= offer;
  end

  // result receiver: rotating stall pattern plus one long hold-off
  always @(posedge clk_i) begin : result_receiver
    logic     take;
    rx_mode_e mode;
    rx_tick++;
    mode = rx_mode_e'((rx_tick / 97) % 4);
    case (mode)
      RX_OPEN:   take = 1'b1;
      RX_HALF:   take = 1'($urandom_range(0, 1));
      RX_SPARSE: take = ($urandom_range(0, 3) == 0);
      default:   take = ((rx_tick % 3) != 0);
    endcase
    if (hold_left > 0) begin
      hold_left--;
      take = 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
      take = 1'b0;
    end
    out_ready_i <= take;
  end

  // result checker
  always @(posedge clk_i) begin : result_checker
    pca_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pulse_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: charge %0d amp %0d",
                   $signed(out_data_o.charge_scaled),
                   $signed(out_data_o.amplitude_scaled));
        mismatches++;
      end else begin
        want = pulse_results.pop_front();
        if (want.charge_scaled !== out_data_o.charge_scaled ||
            want.amplitude_scaled !== out_data_o.amplitude_scaled ||
            want.baseline_bad !== out_data_o.baseline_bad ||
            want.charge_pass !== out_data_o.charge_pass ||
            want.amp_pass !== out_data_o.amp_pass) begin
          if (mismatches < 10)
            $display("exp/got charge %0d/%0d amp %0d/%0d bad %b/%b cp %b/%b ap %b/%b",
                     $signed(want.charge_scaled), $signed(out_data_o.charge_scaled),
                     $signed(want.amplitude_scaled), $signed(out_data_o.amplitude_scaled),
                     want.baseline_bad, out_data_o.baseline_bad,
                     want.charge_pass, out_data_o.charge_pass,
                     want.amp_pass, out_data_o.amp_pass);
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
  endtask

  // all eight registers back to back, only while the block is idle
  task automatic apply_cfg(input cfg_t c);
    cur_cfg = c;
    write_reg(CFG_CHARGE_START,   CFG_DATA_W'(c.charge_start));
    write_reg(CFG_CHARGE_END,     CFG_DATA_W'(c.charge_end));
    write_reg(CFG_MIN_END,        CFG_DATA_W'(c.min_end));
    write_reg(CFG_BASELINE_FLOOR, CFG_DATA_W'(c.baseline_floor));
    write_reg(CFG_CHARGE_LOW,     c.charge_low);
    write_reg(CFG_CHARGE_HIGH,    c.charge_high);
    write_reg(CFG_AMP_LOW,        CFG_DATA_W'($signed(c.amp_low)));
    write_reg(CFG_AMP_HIGH,       CFG_DATA_W'($signed(c.amp_high)));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait for every request taken and every result back, then let the pipe empty
  task automatic drain();
    while (sample_fifo.size() != 0 || in_valid_i || pulse_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  function automatic void push_sample(input logic [15:0] s, input logic last);
    pca_in_t it;
    it.sample = s;
    it.last_sample = last;
    sample_fifo.insert(sample_fifo.size(), it);
  endfunction

  function automatic logic [15:0] wave_sample(input shape_e shape, input int level,
                                              input int k, input int dip_at,
                                              input int depth);
    int v;
    if ($urandom_range(0, 39) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    if (shape == SHAPE_NOISE) return 16'($urandom);
    v = level + int'($urandom_range(0, 200)) - 100;
    // falling edge then slow recovery over sixteen samples
    if (k >= dip_at && k < dip_at + 16) v -= depth * (16 - (k - dip_at)) / 16;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  task automatic queue_waveform(input int len, input shape_e shape);
    int level, dip_at, depth;
    level  = $urandom_range(0, 65535);
    dip_at = $urandom_range(0, len);
    depth  = $urandom_range(0, level);
    for (int k = 0; k < len; k++)
      push_sample(wave_sample(shape, level, k, dip_at, depth), k == len - 1);
  endtask

  function automatic cfg_t pick_cfg(input win_kind_e kind);
    cfg_t c;
    int clo, chi, alo, ahi;
    clo = int'($urandom_range(0, 40000000)) - 20000000;
    chi = clo + int'($urandom_range(0, 40000000)) - 4000000;
    alo = int'($urandom_range(0, 2000000)) - AMP_CUT_MAX;
    ahi = alo + int'($urandom_range(0, 1500000)) - 150000;
    if (ahi > AMP_CUT_MAX) ahi = AMP_CUT_MAX;
    if (ahi < -AMP_CUT_MAX) ahi = -AMP_CUT_MAX;
    c.charge_start = IDX_W'($urandom_range(0, 24));
    c.charge_end   = IDX_W'($urandom_range(0, 48));
    c.min_end      = IDX_W'($urandom_range(0, 48));
    case ($urandom_range(0, 3))
      0:       c.baseline_floor = '0;
      1:       c.baseline_floor = '1;
      default: c.baseline_floor = FLOOR_W'($urandom);
    endcase
    c.charge_low  = CHARGE_W'(clo);
    c.charge_high = CHARGE_W'(chi);
    c.amp_low     = AMP_W'(alo);
    c.amp_high    = AMP_W'(ahi);
    // whole waveform open, widest cuts
    if (kind == WIN_FULL) begin
      c.charge_start   = '0;
      c.charge_end     = '1;
      c.min_end        = '1;
      c.baseline_floor = '0;
      c.charge_low     = CHARGE_W'(-CHG_CUT_MAX);
      c.charge_high    = CHARGE_W'(CHG_CUT_MAX);
      c.amp_low        = AMP_W'(-AMP_CUT_MAX);
      c.amp_high       = AMP_W'(AMP_CUT_MAX);
    end
    // only the very last index in range, cuts inverted
    if (kind == WIN_TOP) begin
      c.charge_start   = '1;
      c.charge_end     = '1;
      c.min_end        = '1;
      c.baseline_floor = '1;
      c.charge_low     = CHARGE_W'(CHG_CUT_MAX);
      c.charge_high    = CHARGE_W'(-CHG_CUT_MAX);
      c.amp_low        = AMP_W'(AMP_CUT_MAX);
      c.amp_high       = AMP_W'(-AMP_CUT_MAX);
    end
    return c;
  endfunction

  // run limit
  initial begin : watchdog
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // stimulus sequence
  initial begin : stimulus
    win_kind_e kind;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: single-sample waveforms and a floor boundary
    push_sample(16'h0000, 1'b1);
    push_sample(16'hFFFF, 1'b1);
    push_sample(16'd14599, 1'b0);
    push_sample(16'd14600, 1'b0);
    push_sample(16'hFFFF, 1'b1);
    drain();

    // narrow window, open cuts, extreme samples
    apply_cfg('{charge_start: IDX_W'(1), charge_end: IDX_W'(4), min_end: IDX_W'(6),
                baseline_floor: FLOOR_W'(100),
                charge_low: CHARGE_W'(-CHG_CUT_MAX), charge_high: CHARGE_W'(CHG_CUT_MAX),
                amp_low: AMP_W'(-AMP_CUT_MAX), amp_high: AMP_W'(AMP_CUT_MAX)});
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'h0001, 1'b0);
    push_sample(16'hFFFE, 1'b0);
    push_sample(16'h5555, 1'b0);
    push_sample(16'hAAAA, 1'b1);
    // waveform shorter than the window
    push_sample(16'd200, 1'b0);
    push_sample(16'd50, 1'b1);
    drain();

    // empty charge window and empty minimum search, only the last baseline sample low
    apply_cfg('{charge_start: IDX_W'(3), charge_end: IDX_W'(0), min_end: IDX_W'(1),
                baseline_floor: '1, charge_low: '0, charge_high: '0,
                amp_low: '0, amp_high: '0});
    repeat (4) push_sample(16'hFFFF, 1'b0);
    push_sample(16'd7, 1'b1);
    drain();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      kind = (ph == 2) ? WIN_FULL : (ph == 6) ? WIN_TOP : WIN_SHORT;
      apply_cfg(pick_cfg(kind));
      // back-pressure: results held off while single-sample waveforms pour in
      if (ph == 3) begin
        hold_go = 1'b1;
        repeat (40) queue_waveform(1, SHAPE_NOISE);
      end
      case (kind)
        WIN_FULL: begin
          queue_waveform($urandom_range(20, 60), SHAPE_PULSE);
          queue_waveform($urandom_range(20, 60), SHAPE_PULSE);
        end
        WIN_TOP: begin
          queue_waveform($urandom_range(1, 40), SHAPE_PULSE);
          queue_waveform($urandom_range(1, 40), SHAPE_NOISE);
        end
        default: begin
          repeat (3)
            queue_waveform(($urandom_range(0, 3) != 0) ? $urandom_range(1, 20) :
                           $urandom_range(21, 60),
                           ($urandom_range(0, 3) == 0) ? SHAPE_NOISE : SHAPE_PULSE);
        end
      endcase
      drain();
    end

    if (mismatches == 0 && pulse_results.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
